>>> rtl/pat_pkg.sv
// ----------------------------------------------------------------------------
// pat_pkg
// Types and codes shared by the pid allocator table modules.
// ----------------------------------------------------------------------------
package pat_pkg;

  localparam int unsigned PidW       = 7;
  localparam int unsigned HandleInW  = 32;
  localparam int unsigned HandleOutW = 32;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]           operation;
    logic [PidW-1:0]      pid;
    logic [HandleInW-1:0] process_handle;
  } pat_req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [PidW-1:0]       pid_out;
    logic [HandleOutW-1:0] handle_out;
  } pat_rsp_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } pat_cmd_t;

endpackage

>>> rtl/pat_ram.sv
// ----------------------------------------------------------------------------
// pat_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pat_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/pat_ctrl.sv
// ----------------------------------------------------------------------------
// pat_ctrl
// Two-state sequencer: capture and read, then execute and write back.
// ----------------------------------------------------------------------------
module pat_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output pat_pkg::pat_cmd_t cmd_o
);
  import pat_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE:  if (start) state_q <= S_EXEC;
        S_EXEC:  state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy          = (state_q == S_EXEC);
  assign cmd_o.capture = start && (state_q == S_IDLE);
  assign cmd_o.execute = (state_q == S_EXEC);

endmodule

>>> rtl/pat_datapath.sv
// ----------------------------------------------------------------------------
// pat_datapath
// Free pid stack, fresh counter, live bits, handle store and result register.
// ----------------------------------------------------------------------------
module pat_datapath #(
  parameter int unsigned TABLE_DEPTH  = 64,
  parameter int unsigned FIRST_PID    = 2,
  parameter int unsigned HANDLE_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pat_pkg::pat_cmd_t cmd_i,
  input  pat_pkg::pat_req_t req_i,
  output logic              done_o,
  output pat_pkg::pat_rsp_t rsp_o
);
  import pat_pkg::*;

  localparam int unsigned SlotW      = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned FreshLimit = FIRST_PID + TABLE_DEPTH;
  localparam int unsigned FreshW     = $clog2(FreshLimit + 1);
  localparam int unsigned CmpW       = (FreshW > PidW) ? FreshW : PidW;
  localparam int unsigned StoreW     = (HANDLE_WIDTH < HandleInW) ? HANDLE_WIDTH : HandleInW;

  logic [1:0]       op_q;
  logic [PidW-1:0]  pid_q;
  logic [StoreW-1:0] handle_q;
  logic [SlotW-1:0] slot_q;
  logic             in_range_q;

  logic [FreshW-1:0] fresh_q, fresh_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [TABLE_DEPTH-1:0] live_q, live_d;
  logic              done_q;
  pat_rsp_t          rsp_q, rsp_d;

  logic [CmpW-1:0]   pid_ext, slot_full, pop_ext, pop_full;
  logic [FreshW-1:0] fresh_slot_full;
  logic              in_range;
  logic [SlotW-1:0]  in_slot, stack_raddr;

  logic              stk_we, hdl_we;
  logic [SlotW-1:0]  stk_waddr, hdl_waddr;
  logic [PidW-1:0]   stk_rdata;
  logic [StoreW-1:0] hdl_rdata;
  logic              live_hit;

  assign pid_ext   = CmpW'(req_i.pid);
  assign slot_full = pid_ext - CmpW'(FIRST_PID);
  assign in_range  = (pid_ext >= CmpW'(FIRST_PID)) && (pid_ext < CmpW'(FreshLimit));
  assign in_slot   = slot_full[SlotW-1:0];

  assign stack_raddr = SlotW'(count_q - CntW'(1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q       <= req_i.operation;
      pid_q      <= req_i.pid;
      handle_q   <= req_i.process_handle[StoreW-1:0];
      slot_q     <= in_slot;
      in_range_q <= in_range;
    end
  end

  assign pop_ext         = CmpW'(stk_rdata);
  assign pop_full        = pop_ext - CmpW'(FIRST_PID);
  assign fresh_slot_full = fresh_q - FreshW'(FIRST_PID);
  assign live_hit        = in_range_q && live_q[slot_q];

  always_comb begin
    fresh_d   = fresh_q;
    count_d   = count_q;
    live_d    = live_q;
    rsp_d     = '0;
    rsp_d.status = ST_NOT_FOUND;
    stk_we    = 1'b0;
    stk_waddr = count_q[SlotW-1:0];
    hdl_we    = 1'b0;
    hdl_waddr = pop_full[SlotW-1:0];
    if (cmd_i.execute) begin
      unique case (op_q)
        OP_ADD: begin
          if (count_q != '0) begin
            count_d          = count_q - CntW'(1);
            hdl_we           = 1'b1;
            hdl_waddr        = pop_full[SlotW-1:0];
            live_d[hdl_waddr] = 1'b1;
            rsp_d.status     = ST_OK;
            rsp_d.pid_out    = stk_rdata;
          end else if (fresh_q < FreshW'(FreshLimit)) begin
            fresh_d          = fresh_q + FreshW'(1);
            hdl_we           = 1'b1;
            hdl_waddr        = fresh_slot_full[SlotW-1:0];
            live_d[hdl_waddr] = 1'b1;
            rsp_d.status     = ST_OK;
            rsp_d.pid_out    = PidW'(fresh_q);
          end else begin
            rsp_d.status = ST_FULL;
          end
        end
        OP_REMOVE: begin
          if (live_hit) begin
            live_d[slot_q] = 1'b0;
            if (count_q < CntW'(TABLE_DEPTH)) begin
              stk_we  = 1'b1;
              count_d = count_q + CntW'(1);
            end
            rsp_d.status = ST_OK;
          end
        end
        OP_LOOKUP: begin
          if (live_hit) begin
            rsp_d.status     = ST_OK;
            rsp_d.handle_out = HandleOutW'(hdl_rdata);
          end
        end
        default: rsp_d.status = ST_NOT_FOUND;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= FreshW'(FIRST_PID);
      count_q <= '0;
      live_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      fresh_q <= fresh_d;
      count_q <= count_d;
      live_q  <= live_d;
      done_q  <= cmd_i.execute;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      rsp_q <= rsp_d;
    end
  end

  pat_ram #(
    .Width (PidW),
    .Depth (TABLE_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (pid_q),
    .re_i    (cmd_i.capture),
    .raddr_i (stack_raddr),
    .rdata_o (stk_rdata)
  );

  pat_ram #(
    .Width (StoreW),
    .Depth (TABLE_DEPTH)
  ) u_handle_ram (
    .clk_i   (clk_i),
    .we_i    (hdl_we),
    .waddr_i (hdl_waddr),
    .wdata_i (handle_q),
    .re_i    (cmd_i.capture),
    .raddr_i (in_slot),
    .rdata_o (hdl_rdata)
  );

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

>>> rtl/pid_allocator_table_core.sv
// ----------------------------------------------------------------------------
// pid_allocator_table_core
// Pid allocator with a free pid stack, a fresh pid counter and a handle table.
//
//   port     dir  role
//   start    in   item request, taken when busy is low
//   busy     out  sequencer in its execute cycle
//   req_i    in   item: operation, pid, process_handle
//   done_o   out  one-cycle result strobe
//   rsp_o    out  result: status, pid_out, handle_out
//
// The accept cycle captures the item and launches the stack and handle reads;
// the execute state then decides and writes back. The result strobe is up
// the cycle after that, while the next item may already be accepted. The
// receiver cannot stall. Reset empties the stack count, sets the fresh
// counter to FIRST_PID and clears the live bits at once; no clearing pass.
// ----------------------------------------------------------------------------
module pid_allocator_table_core #(
  parameter int unsigned TABLE_DEPTH  = 64,
  parameter int unsigned FIRST_PID    = 2,
  parameter int unsigned HANDLE_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  pat_pkg::pat_req_t req_i,
  output logic              done_o,
  output pat_pkg::pat_rsp_t rsp_o
);
  import pat_pkg::*;

  pat_cmd_t cmd;

  pat_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  pat_datapath #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .FIRST_PID    (FIRST_PID),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule
